[rtl/core/hsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared Q1.16 types, pipeline stage records and helpers for the HSV to RGB
// conversion pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_WIDTH   = FRAC_BITS + 1;
    localparam int SEC_WIDTH = 3;
    localparam int CHAN_W    = 8;

    localparam logic [Q_WIDTH-1:0] Q_ONE = Q_WIDTH'(1) << FRAC_BITS;
    localparam logic [2:0]         SECTORS = 3'd6;
    localparam logic [CHAN_W-1:0]  CHAN_MAX = 8'd255;

    typedef logic [Q_WIDTH-1:0]   t_q16;
    typedef logic [FRAC_BITS-1:0] t_frac;
    typedef logic [CHAN_W-1:0]    t_chan;

    typedef enum logic [SEC_WIDTH-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // After sector split: clamped operands and hue fraction.
    typedef struct packed {
        t_sector sector;
        t_q16    one_minus_f;
        t_frac   f;
        t_q16    sat;
        t_q16    val;
    } t_stage1;

    // After first product rank.
    typedef struct packed {
        t_sector sector;
        t_q16    val;
        t_q16    p;
        t_frac   sf;
        t_q16    sif;
    } t_stage2;

    // All three terms ready for channel routing.
    typedef struct packed {
        t_sector sector;
        t_q16    val;
        t_q16    p;
        t_q16    q;
        t_q16    t;
    } t_stage3;

    // Levels above one saturate to one; bits above the Q1.16 field are ignored.
    function automatic t_q16 clamp_one(input t_q16 x);
        clamp_one = (x > Q_ONE) ? Q_ONE : x;
    endfunction

    // Only a level of exactly one reaches 256 after the shift.
    function automatic t_chan to_byte(input t_q16 level);
        to_byte = level[FRAC_BITS] ? CHAN_MAX : level[FRAC_BITS-1:FRAC_BITS-CHAN_W];
    endfunction

endpackage
`default_nettype wire

[rtl/core/hsv_sector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_sector
// First stage: clamps the operands, wraps a full hue to zero and splits hue
// times six into a sector number and a 16-bit fraction.
// ----------------------------------------------------------------------------
module hsv_sector
    import hsv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_ce,
    input  wire logic    i_valid,
    input  wire t_q16    i_hue,
    input  wire t_q16    i_sat,
    input  wire t_q16    i_val,
    output logic         o_valid,
    output t_stage1      o_data
);

    logic                  r_valid;
    t_stage1               r_data;
    t_stage1               n_data;
    t_q16                  hue_c;
    logic [Q_WIDTH+1:0]    h6;

    always_comb begin
        hue_c = clamp_one(i_hue);
        if (hue_c == Q_ONE) begin
            hue_c = '0;
        end
        h6 = {2'b00, hue_c} * {{(Q_WIDTH-1){1'b0}}, SECTORS};
        n_data.sector      = t_sector'(h6[FRAC_BITS+SEC_WIDTH-1:FRAC_BITS]);
        n_data.f           = h6[FRAC_BITS-1:0];
        n_data.one_minus_f = Q_ONE - {1'b0, h6[FRAC_BITS-1:0]};
        n_data.sat         = clamp_one(i_sat);
        n_data.val         = clamp_one(i_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
        if (i_ce) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[rtl/core/hsv_terms.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_terms
// Two multiplier ranks: the first forms p, s*f and s*(1-f), the second
// scales the complements by the value to give q and t.
// ----------------------------------------------------------------------------
module hsv_terms
    import hsv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_ce,
    input  wire logic    i_valid,
    input  wire t_stage1 i_data,
    output logic         o_valid,
    output t_stage3      o_data
);

    logic                  r_valid2;
    logic                  r_valid3;
    t_stage2               r_s2;
    t_stage2               n_s2;
    t_stage3               r_s3;
    t_stage3               n_s3;
    logic [2*Q_WIDTH-1:0]  prod_sf;
    logic [2*Q_WIDTH-1:0]  prod_sif;
    logic [2*Q_WIDTH-1:0]  prod_p;
    logic [2*Q_WIDTH-1:0]  prod_q;
    logic [2*Q_WIDTH-1:0]  prod_t;

    always_comb begin
        prod_sf  = {{Q_WIDTH{1'b0}}, i_data.sat} * {{(Q_WIDTH+1){1'b0}}, i_data.f};
        prod_sif = {{Q_WIDTH{1'b0}}, i_data.sat} * {{Q_WIDTH{1'b0}}, i_data.one_minus_f};
        prod_p   = {{Q_WIDTH{1'b0}}, i_data.val} * {{Q_WIDTH{1'b0}}, (Q_ONE - i_data.sat)};
        n_s2.sector = i_data.sector;
        n_s2.val    = i_data.val;
        n_s2.p      = prod_p[FRAC_BITS+Q_WIDTH-1:FRAC_BITS];
        n_s2.sf     = prod_sf[2*FRAC_BITS-1:FRAC_BITS];
        n_s2.sif    = prod_sif[FRAC_BITS+Q_WIDTH-1:FRAC_BITS];
    end

    always_comb begin
        prod_q = {{Q_WIDTH{1'b0}}, r_s2.val} *
                 {{Q_WIDTH{1'b0}}, (Q_ONE - {1'b0, r_s2.sf})};
        prod_t = {{Q_WIDTH{1'b0}}, r_s2.val} * {{Q_WIDTH{1'b0}}, (Q_ONE - r_s2.sif)};
        n_s3.sector = r_s2.sector;
        n_s3.val    = r_s2.val;
        n_s3.p      = r_s2.p;
        n_s3.q      = prod_q[FRAC_BITS+Q_WIDTH-1:FRAC_BITS];
        n_s3.t      = prod_t[FRAC_BITS+Q_WIDTH-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_ce) begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
        if (i_ce) begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_valid3;
    assign o_data  = r_s3;

endmodule
`default_nettype wire

[rtl/core/hsv_route.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_route
// Output stage: routes value, p, q and t to the channels by sector and
// reduces each level to a saturated byte.
// ----------------------------------------------------------------------------
module hsv_route
    import hsv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_ce,
    input  wire logic    i_valid,
    input  wire t_stage3 i_data,
    output logic         o_valid,
    output t_chan        o_red,
    output t_chan        o_green,
    output t_chan        o_blue
);

    logic  r_valid;
    t_chan r_red;
    t_chan r_green;
    t_chan r_blue;
    t_q16  lvl_r;
    t_q16  lvl_g;
    t_q16  lvl_b;

    always_comb begin
        unique case (i_data.sector)
            SEC_RED_YEL: begin
                lvl_r = i_data.val; lvl_g = i_data.t;   lvl_b = i_data.p;
            end
            SEC_YEL_GRN: begin
                lvl_r = i_data.q;   lvl_g = i_data.val; lvl_b = i_data.p;
            end
            SEC_GRN_CYN: begin
                lvl_r = i_data.p;   lvl_g = i_data.val; lvl_b = i_data.t;
            end
            SEC_CYN_BLU: begin
                lvl_r = i_data.p;   lvl_g = i_data.q;   lvl_b = i_data.val;
            end
            SEC_BLU_MAG: begin
                lvl_r = i_data.t;   lvl_g = i_data.p;   lvl_b = i_data.val;
            end
            default: begin
                lvl_r = i_data.val; lvl_g = i_data.p;   lvl_b = i_data.q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
        if (i_ce) begin
            r_red   <= to_byte(lvl_r);
            r_green <= to_byte(lvl_g);
            r_blue  <= to_byte(lvl_b);
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule
`default_nettype wire

[rtl/core/hsv_to_rgb_converter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted request passes in order through the sector split, the two
// multiplier ranks and the routing stage, whose register is the output; every stage
// holds while the output side is stalled.
// Throughput: one pixel per clock cycle; the rate is set by the pipeline enable,
// which holds every stage while the output register holds an untaken result.
// Reset: synchronous, active low; clears all stage valid bits, data is not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Streaming HSV to RGB pixel converter built as a four-stage pipeline.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
    import hsv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // Fields from bit 0 up: hue[16:0], saturation[33:17], brightness[50:34], zero pad.
    input  wire logic [55:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // Fields from bit 0 up: red[7:0], green[15:8], blue[23:16].
    output logic [23:0]      o_m_axis_tdata
);

    // All stages advance together. The whole pipeline moves whenever the
    // output register is empty or its result is being taken, so bubbles are
    // carried along rather than squeezed out, and nothing is dropped or
    // repeated on a stall.
    logic    ce;
    logic    s1_valid;
    t_stage1 s1_data;
    logic    s3_valid;
    t_stage3 s3_data;
    t_chan   red;
    t_chan   green;
    t_chan   blue;

    assign ce              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // Stage 1: clamp, hue wrap, sector and fraction.
    hsv_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_s_axis_tvalid),
        .i_hue   (i_s_axis_tdata[16:0]),
        .i_sat   (i_s_axis_tdata[33:17]),
        .i_val   (i_s_axis_tdata[50:34]),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    // Stages 2 and 3: the p, q and t terms. Zero saturation needs no special
    // path, since every term then equals the value level.
    hsv_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s3_valid),
        .o_data  (s3_data)
    );

    // Stage 4: channel routing and byte saturation; this is the output register.
    hsv_route u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s3_valid),
        .i_data  (s3_data),
        .o_valid (o_m_axis_tvalid),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    assign o_m_axis_tdata = {blue, green, red};

endmodule
`default_nettype wire

[rtl/core/hsv_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // The input side stalls only while a result waits at the output.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output state");

    // An accepted request reaches the output when nothing stalls.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready
            ##1 i_m_axis_tready ##1 i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted request did not reach the output");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

[tb/sv/hsv_rgb_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rgb_scoreboard_pkg
// Pixel scoreboard for the HSV to RGB converter: predicts the RGB bytes of
// each accepted request and compares them with the pixels that come out.
// ----------------------------------------------------------------------------
package hsv_rgb_scoreboard_pkg;
    import hsv_pkg::*;

    typedef struct {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb_pixel;

    class hsv_rgb_scoreboard;
        t_rgb_pixel pending_pixels[$];
        int unsigned mismatches = 0;
        int unsigned requests_seen = 0;
        int unsigned pixels_checked = 0;

        // Levels above one saturate to one.
        function t_q16 limit_to_one(t_q16 x);
            return (x > Q_ONE) ? Q_ONE : x;
        endfunction

        // Q1.16 product, truncated back to 16 fraction bits.
        function t_q16 frac_mul(t_q16 a, t_q16 b);
            logic [33:0] prod;
            prod = 34'(a) * 34'(b);
            return t_q16'(prod >> FRAC_BITS);
        endfunction

        function t_chan level_to_byte(t_q16 level);
            t_q16 shifted;
            shifted = level >> 8;
            return (shifted > t_q16'(CHAN_MAX)) ? CHAN_MAX : shifted[CHAN_W-1:0];
        endfunction

        function t_rgb_pixel predict_rgb(t_q16 hue_in, t_q16 sat_in, t_q16 val_in);
            t_q16        h, s, v, p, q, t, r, g, b;
            logic [19:0] h6;
            t_sector     sector;
            t_q16        f;
            t_rgb_pixel  px;
            h = limit_to_one(hue_in);
            s = limit_to_one(sat_in);
            v = limit_to_one(val_in);
            if (s == '0) begin
                r = v;
                g = v;
                b = v;
            end else begin
                if (h >= Q_ONE) h = '0;
                h6 = 20'(h) * 20'd6;
                sector = t_sector'(h6[18:16]);
                f = {1'b0, h6[15:0]};
                p = frac_mul(v, Q_ONE - s);
                q = frac_mul(v, Q_ONE - frac_mul(s, f));
                t = frac_mul(v, Q_ONE - frac_mul(s, Q_ONE - f));
                case (sector)
                    SEC_RED_YEL: begin r = v; g = t; b = p; end
                    SEC_YEL_GRN: begin r = q; g = v; b = p; end
                    SEC_GRN_CYN: begin r = p; g = v; b = t; end
                    SEC_CYN_BLU: begin r = p; g = q; b = v; end
                    SEC_BLU_MAG: begin r = t; g = p; b = v; end
                    default:     begin r = v; g = p; b = q; end
                endcase
            end
            px.red   = level_to_byte(r);
            px.green = level_to_byte(g);
            px.blue  = level_to_byte(b);
            return px;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] pixel error: %s", $time, msg);
        endtask

        function void note_request(t_q16 hue, t_q16 sat, t_q16 val);
            requests_seen++;
            pending_pixels.push_back(predict_rgb(hue, sat, val));
        endfunction

        task check_result(logic [23:0] data);
            t_rgb_pixel want;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %06h arrived with no request waiting", data));
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (data[7:0] !== want.red)
                    report_mismatch($sformatf("pixel %0d red %0d, want %0d",
                                              pixels_checked, data[7:0], want.red));
                if (data[15:8] !== want.green)
                    report_mismatch($sformatf("pixel %0d green %0d, want %0d",
                                              pixels_checked, data[15:8], want.green));
                if (data[23:16] !== want.blue)
                    report_mismatch($sformatf("pixel %0d blue %0d, want %0d",
                                              pixels_checked, data[23:16], want.blue));
            end
        endtask

        function int unsigned pending();
            return pending_pixels.size();
        endfunction

        task flag_leftovers();
            if (pending_pixels.size() != 0)
                report_mismatch($sformatf("%0d predicted pixels never came out",
                                          pending_pixels.size()));
        endtask
    endclass

endpackage

[tb/sv/hsv_to_rgb_converter_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top_test
// Drives HSV pixel requests into the converter, predicts every RGB pixel and
// checks the output stream under several patterns of input gaps and stalls.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top_test;
    import hsv_pkg::*;
    import hsv_rgb_scoreboard_pkg::*;

    // Every input of the block starts from a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // Fields from bit 0 up: hue[16:0], saturation[33:17], brightness[50:34], zero pad.
    logic [55:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // Fields from bit 0 up: red[7:0], green[15:8], blue[23:16].
    logic [23:0] o_m_axis_tdata;

    // Idle rates in percent for the current phase, and the remaining length of
    // a long output hold-off that the receiver process counts down.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;

    hsv_rgb_scoreboard sb;

    // Directed pixels: extreme levels, grey, over-range fields, one pixel in
    // each sector and hues right at the sector boundaries.
    int unsigned dir_hue[] = '{0, 0, 0, 12345, 0, 65536, 131071, 65537,
                               5000, 16000, 27000, 38000, 49000, 60000,
                               10922, 10923, 21845, 21846, 54613, 54614,
                               30000, 30000, 30000, 0, 65535};
    int unsigned dir_sat[] = '{0, 0, 0, 0, 65536, 65536, 65536, 40000,
                               65536, 65536, 65536, 65536, 65536, 65536,
                               65536, 65536, 65536, 65536, 65536, 65536,
                               131071, 65536, 65536, 1, 65535};
    int unsigned dir_val[] = '{0, 65536, 131071, 40000, 65536, 65536, 65536, 50000,
                               65536, 65536, 65536, 65536, 65536, 65536,
                               65536, 65536, 65536, 65536, 65536, 65536,
                               65536, 255, 256, 65536, 65535};

    hsv_to_rgb_converter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run, including the long stall.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Both handshakes are sampled at the rising edge, where the inputs driven
    // at the falling edge are stable and the block's outputs still hold the
    // values of the cycle that is ending.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_request(i_s_axis_tdata[16:0], i_s_axis_tdata[33:17],
                                i_s_axis_tdata[50:34]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
        end
    end

    // Receiver: stalls at the phase rate, or holds tready low for the whole of
    // a requested hold-off so that the pipeline fills and backs up its input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Mostly legal levels, with both ends and full 17-bit noise mixed in so
    // every bit, including the over-range ones, gets exercised.
    function automatic t_q16 rand_level();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 10) return Q_ONE;
        if (pick < 18) return t_q16'($urandom_range(131071));
        return t_q16'($urandom_range(65535));
    endfunction

    // Hue biased now and then toward a sector boundary.
    function automatic t_q16 rand_hue();
        int hb;
        if ($urandom_range(99) < 15) begin
            hb = ($urandom_range(6) * 65536) / 6 + $urandom_range(4) - 2;
            if (hb < 0) hb = 0;
            return t_q16'(hb);
        end
        return rand_level();
    endfunction

    // Offers one pixel request. Called and returning at a falling edge; tvalid
    // gets a single assignment per time step, so back-to-back requests keep it
    // high without a glitch.
    task automatic send_pixel(input t_q16 hue, input t_q16 sat, input t_q16 val);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, val, sat, hue};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Drops tvalid after the last request and waits until every predicted
    // pixel has come out.
    task automatic drain_pixels();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned s_pct,
                             input int unsigned r_pct, input bit long_hold);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        if (long_hold) hold_left = 250;
        repeat (n) send_pixel(rand_hue(), rand_level(), rand_level());
        drain_pixels();
    endtask

    initial begin
        sb = new();
        // One synchronous reset at the start of the run.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pixels with no idling on either side.
        foreach (dir_hue[k])
            send_pixel(t_q16'(dir_hue[k]), t_q16'(dir_sat[k]), t_q16'(dir_val[k]));
        drain_pixels();

        // Random phases: a full-rate stretch that opens with a long output
        // hold-off, then input gaps, output stalls, and both together.
        run_phase(300, 0, 0, 1'b1);
        run_phase(300, 77, 0, 1'b0);
        run_phase(300, 0, 77, 1'b0);
        run_phase(300, 25, 25, 1'b0);

        // An idle wait follows to catch any pixel the block should not send.
        repeat (16) @(posedge i_clk);
        sb.flag_leftovers();

        $display("Sent %0d pixel requests (directed extremes, sector edges, random levels),",
                 sb.requests_seen);
        $display("checked %0d pixels across full-rate, gapped, stalled and held-off phases.",
                 sb.pixels_checked);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
